// ----- rtl/core/lhfh_pkg.sv -----
// Shared constants, types and codes for the lidar scan hole-fill and hold block.
// Used by lhfh_cell, lhfh_hold_mem and lidar_scan_hole_fill_hold; depends on nothing.
`default_nettype none

package lhfh_pkg;

    // Scan geometry.
    localparam int BINS        = 360;
    localparam int HALF_WIN    = 2;
    localparam int WIN_CELLS   = 2 * HALF_WIN + 1;
    localparam int HEAD_CELLS  = 2 * HALF_WIN;

    // Field widths.
    localparam int BIN_W     = $clog2(BINS);
    localparam int CFG_BIN_W = 9;
    localparam int CMP_W     = (BIN_W > CFG_BIN_W) ? BIN_W : CFG_BIN_W;
    localparam int RANGE_W   = 16;
    localparam int STAMP_W   = 48;
    localparam int HOLD_T_W  = 32;
    localparam int FLUSH_W   = (HEAD_CELLS > 1) ? $clog2(HEAD_CELLS) : 1;

    typedef logic [BIN_W-1:0]     bin_t;
    typedef logic [CMP_W-1:0]     cmp_t;
    typedef logic [CFG_BIN_W-1:0] cfg_bin_t;
    typedef logic [RANGE_W-1:0]   range_t;
    typedef logic [STAMP_W-1:0]   stamp_t;
    typedef logic [HOLD_T_W-1:0]  hold_time_t;
    typedef logic [FLUSH_W-1:0]   flush_t;

    // Register reset values.
    localparam cfg_bin_t   FRONT_FIRST_RST = 9'd0;
    localparam cfg_bin_t   FRONT_LAST_RST  = 9'd180;
    localparam hold_time_t HOLD_TIME_RST   = 32'd500000;
    localparam range_t     CLEAR_RANGE_RST = 16'd8000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FRONT_FIRST = 2'd0,
        REG_FRONT_LAST  = 2'd1,
        REG_HOLD_TIME   = 2'd2,
        REG_CLEAR_RANGE = 2'd3
    } cfg_idx_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_MEASURED = 3'd0,
        ST_FILLED   = 3'd1,
        ST_HELD     = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_CLEAR    = 3'd4
    } status_t;

    // One entry of the per-bin hold store.
    typedef struct packed {
        range_t range;
        stamp_t stamp;
    } hold_ent_t;

    // Write port of the hold store.
    typedef struct packed {
        logic      en;
        bin_t      addr;
        hold_ent_t ent;
    } hold_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/lhfh_cell.sv -----
// One cell of the sliding sample window: holds a raw sample and passes it on.
// Also folds its sample into the running nonzero minimum; uses lhfh_pkg.
`default_nettype none

module lhfh_cell (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire lhfh_pkg::range_t din,
    output lhfh_pkg::range_t     dout,
    input  wire lhfh_pkg::range_t min_in,
    output lhfh_pkg::range_t     min_out
);

    lhfh_pkg::range_t sample_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= din;
        end
    end

    assign dout = sample_reg;

    // Zero means no return and never wins the minimum.
    always_comb
    begin
        if (sample_reg != '0 && (min_in == '0 || sample_reg < min_in))
        begin
            min_out = sample_reg;
        end
        else
        begin
            min_out = min_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lhfh_hold_mem.sv -----
// Per-bin hold store: last good range and its frame time, one entry per bin.
// Runs a clearing pass after reset and reports busy meanwhile; uses lhfh_pkg.
`default_nettype none

module lhfh_hold_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lhfh_pkg::hold_wr_t wr,
    input  wire logic              rd_en,
    input  wire lhfh_pkg::bin_t    rd_addr,
    output lhfh_pkg::hold_ent_t    rd_data,
    output logic                   busy
);

    lhfh_pkg::hold_ent_t mem [lhfh_pkg::BINS];
    lhfh_pkg::hold_ent_t rd_data_reg;
    lhfh_pkg::bin_t      clr_cnt_reg;
    logic                busy_reg;

    // Clearing pass: one entry per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (clr_cnt_reg == lhfh_pkg::bin_t'(lhfh_pkg::BINS - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= '{range: lhfh_pkg::CLEAR_RANGE_RST, stamp: '0};
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.ent;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lidar_scan_hole_fill_hold.sv -----
// Top level of the lidar scan hole-fill and hold cleaner.
// Uses lhfh_pkg, lhfh_cell (sample window chain) and lhfh_hold_mem (hold store).
`default_nettype none

// The block takes one raw lidar range word per bin, in bin order 0 to BINS-1, and
// returns one cleaned word per bin with its index and a status: measured, filled
// from the smallest nonzero neighbor within HALF_WIN bins (front window only),
// held from the bin's last good value while it is no older than hold_time_us,
// unknown, or clear outside the front window. Results lag the input by
// HALF_WIN bins; the last word of a scan releases the result of bin BINS-1-HALF_WIN
// and then the wrapped-around bins (BINS-HALF_WIN..BINS-1, then 0..HALF_WIN-1),
// with tlast marking the final result caused by each input word. Throughput is
// one word per cycle in and out while m_tready stays high and no flush or clearing
// pass runs. After the last word of a scan no input is taken while the wrapped bins
// are judged, one per cycle when not stalled, by feeding the stored head samples
// of the scan back through the window chain. Each result passes the judge stage and
// the output register. After reset the hold store clears all BINS entries, taking
// no input word meanwhile; configuration writes are taken at any time but should
// only be made while idle. The frame time, taken from bin 0, serves the whole scan.

module lidar_scan_hole_fill_hold (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [15:0] sample_mm, [63:16] frame_time_us

    // Output stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [8:0] bin_number, [24:9] range_mm, [31:25] zero
    output logic [2:0]       m_tuser,   // [2:0] status
    output logic             m_tlast    // last_of_run
);

    // Configuration registers.
    lhfh_pkg::cfg_bin_t   front_first_reg;
    lhfh_pkg::cfg_bin_t   front_last_reg;
    lhfh_pkg::hold_time_t hold_time_reg;
    lhfh_pkg::range_t     clear_range_reg;

    // Scan control.
    lhfh_pkg::bin_t   bin_cnt_reg;
    lhfh_pkg::stamp_t frame_stamp_reg;
    logic             flushing_reg;
    lhfh_pkg::flush_t flush_cnt_reg;

    // Judge stage.
    logic             jv_reg;
    lhfh_pkg::bin_t   jbin_reg;
    logic             jlast_reg;

    // Output register.
    logic               out_valid_reg;
    lhfh_pkg::cfg_bin_t out_bin_reg;
    lhfh_pkg::range_t   out_range_reg;
    lhfh_pkg::status_t  out_status_reg;
    logic               out_last_reg;

    // Handshake and pipeline control.
    logic             advance;
    logic             accept;
    logic             fstep;
    logic             shift;
    logic             emit;
    logic             last_bin;
    lhfh_pkg::bin_t   jbin_next;
    logic             jlast_next;

    // Window and head chains.
    lhfh_pkg::range_t sample_in;
    lhfh_pkg::range_t win_in;
    lhfh_pkg::range_t win_q     [lhfh_pkg::WIN_CELLS];
    lhfh_pkg::range_t min_chain [lhfh_pkg::WIN_CELLS];
    lhfh_pkg::range_t head_reg  [lhfh_pkg::HEAD_CELLS];
    logic             head_shift;
    lhfh_pkg::range_t head_in;

    // Hold store.
    lhfh_pkg::hold_wr_t  hold_wr;
    lhfh_pkg::hold_ent_t hold_rd;
    logic                mem_busy;

    // Judgment.
    lhfh_pkg::range_t         raw;
    lhfh_pkg::range_t         best;
    logic                     in_window;
    logic [lhfh_pkg::STAMP_W:0] age;
    logic                     fresh;
    lhfh_pkg::range_t         j_range;
    lhfh_pkg::status_t        j_status;

    assign sample_in = s_tdata[15:0];

    // The judge stage moves on when it is empty or the output register is free or
    // being emptied. The window only shifts when the judge stage can take the next
    // bin, so the window contents always match the bin under judgment.
    assign advance  = !jv_reg || !out_valid_reg || m_tready;
    assign s_tready = advance && !flushing_reg && !mem_busy;
    assign accept   = s_tvalid && s_tready;
    assign fstep    = advance && flushing_reg;
    assign shift    = accept || fstep;
    assign last_bin = (bin_cnt_reg == lhfh_pkg::bin_t'(lhfh_pkg::BINS - 1));

    // During the wrap-around flush the head samples of the scan re-enter the window.
    assign win_in = accept ? sample_in : head_reg[0];

    assign emit = (accept && bin_cnt_reg >= lhfh_pkg::bin_t'(lhfh_pkg::HEAD_CELLS)) || fstep;

    always_comb
    begin
        if (fstep)
        begin
            if (flush_cnt_reg < lhfh_pkg::flush_t'(lhfh_pkg::HALF_WIN))
            begin
                jbin_next = lhfh_pkg::bin_t'(lhfh_pkg::BINS - lhfh_pkg::HALF_WIN)
                          + lhfh_pkg::bin_t'(flush_cnt_reg);
            end
            else
            begin
                jbin_next = lhfh_pkg::bin_t'(flush_cnt_reg)
                          - lhfh_pkg::bin_t'(lhfh_pkg::HALF_WIN);
            end
            jlast_next = (flush_cnt_reg == lhfh_pkg::flush_t'(lhfh_pkg::HEAD_CELLS - 1));
        end
        else
        begin
            jbin_next  = bin_cnt_reg - lhfh_pkg::bin_t'(lhfh_pkg::HALF_WIN);
            jlast_next = !last_bin;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_first_reg <= lhfh_pkg::FRONT_FIRST_RST;
            front_last_reg  <= lhfh_pkg::FRONT_LAST_RST;
            hold_time_reg   <= lhfh_pkg::HOLD_TIME_RST;
            clear_range_reg <= lhfh_pkg::CLEAR_RANGE_RST;
        end
        else if (cfg_we)
        begin
            unique case (lhfh_pkg::cfg_idx_t'(cfg_index))
                lhfh_pkg::REG_FRONT_FIRST: front_first_reg <= cfg_data[8:0];
                lhfh_pkg::REG_FRONT_LAST:  front_last_reg  <= cfg_data[8:0];
                lhfh_pkg::REG_HOLD_TIME:   hold_time_reg   <= cfg_data;
                lhfh_pkg::REG_CLEAR_RANGE: clear_range_reg <= cfg_data[15:0];
                default:                   ;
            endcase
        end
    end

    // Scan position, frame time and wrap-around flush.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_cnt_reg     <= '0;
            frame_stamp_reg <= '0;
            flushing_reg    <= 1'b0;
            flush_cnt_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (bin_cnt_reg == '0)
                begin
                    frame_stamp_reg <= s_tdata[63:16];
                end
                if (last_bin)
                begin
                    bin_cnt_reg   <= '0;
                    flushing_reg  <= (lhfh_pkg::HALF_WIN > 0);
                    flush_cnt_reg <= '0;
                end
                else
                begin
                    bin_cnt_reg <= bin_cnt_reg + 1'b1;
                end
            end
            else if (fstep)
            begin
                if (flush_cnt_reg == lhfh_pkg::flush_t'(lhfh_pkg::HEAD_CELLS - 1))
                begin
                    flushing_reg <= 1'b0;
                end
                else
                begin
                    flush_cnt_reg <= flush_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Sliding window of 2*HALF_WIN+1 cells; the center cell is the judged bin.
    for (genvar j = 0; j < lhfh_pkg::WIN_CELLS; j++)
    begin : g_win
        lhfh_pkg::range_t cell_din;
        lhfh_pkg::range_t cell_min_in;

        if (j == lhfh_pkg::WIN_CELLS - 1)
        begin : g_tail
            assign cell_din = win_in;
        end
        else
        begin : g_body
            assign cell_din = win_q[j+1];
        end

        if (j == 0)
        begin : g_first
            assign cell_min_in = '0;
        end
        else
        begin : g_rest
            assign cell_min_in = min_chain[j-1];
        end

        lhfh_cell u_cell (
            .clk     (clk),
            .shift   (shift),
            .din     (cell_din),
            .dout    (win_q[j]),
            .min_in  (cell_min_in),
            .min_out (min_chain[j])
        );
    end

    // Head samples: the first 2*HALF_WIN words of the scan, replayed at its end.
    assign head_shift = (accept && bin_cnt_reg < lhfh_pkg::bin_t'(lhfh_pkg::HEAD_CELLS))
                      || fstep;
    assign head_in    = accept ? sample_in : '0;

    for (genvar k = 0; k < lhfh_pkg::HEAD_CELLS; k++)
    begin : g_head
        if (k == lhfh_pkg::HEAD_CELLS - 1)
        begin : g_tail
            always_ff @(posedge clk)
            begin
                if (head_shift)
                begin
                    head_reg[k] <= head_in;
                end
            end
        end
        else
        begin : g_body
            always_ff @(posedge clk)
            begin
                if (head_shift)
                begin
                    head_reg[k] <= head_reg[k+1];
                end
            end
        end
    end

    // Hold store: read on entry to judgment, written on exit if measured or filled.
    lhfh_hold_mem u_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (hold_wr),
        .rd_en   (emit),
        .rd_addr (jbin_next),
        .rd_data (hold_rd),
        .busy    (mem_busy)
    );

    // Judgment of the center bin.
    assign raw  = win_q[lhfh_pkg::HALF_WIN];
    assign best = min_chain[lhfh_pkg::WIN_CELLS-1];
    assign in_window = (lhfh_pkg::cmp_t'(jbin_reg) >= lhfh_pkg::cmp_t'(front_first_reg))
                    && (lhfh_pkg::cmp_t'(jbin_reg) <= lhfh_pkg::cmp_t'(front_last_reg));

    // A hold stamp later than the frame time also counts as fresh.
    assign age   = {1'b0, frame_stamp_reg} - {1'b0, hold_rd.stamp};
    assign fresh = age[lhfh_pkg::STAMP_W]
                || (age[lhfh_pkg::STAMP_W-1:0] <= lhfh_pkg::stamp_t'(hold_time_reg));

    always_comb
    begin
        if (raw != '0)
        begin
            j_range  = raw;
            j_status = lhfh_pkg::ST_MEASURED;
        end
        else if (in_window)
        begin
            if (best != '0)
            begin
                j_range  = best;
                j_status = lhfh_pkg::ST_FILLED;
            end
            else if (fresh)
            begin
                j_range  = hold_rd.range;
                j_status = lhfh_pkg::ST_HELD;
            end
            else
            begin
                j_range  = '0;
                j_status = lhfh_pkg::ST_UNKNOWN;
            end
        end
        else
        begin
            j_range  = clear_range_reg;
            j_status = lhfh_pkg::ST_CLEAR;
        end
    end

    always_comb
    begin
        hold_wr.en        = advance && jv_reg
                         && (j_status == lhfh_pkg::ST_MEASURED
                          || j_status == lhfh_pkg::ST_FILLED);
        hold_wr.addr      = jbin_reg;
        hold_wr.ent.range = j_range;
        hold_wr.ent.stamp = frame_stamp_reg;
    end

    // Judge stage and output register. The output register keeps its word until
    // it is taken, even when an empty judge stage lets the window move on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                jv_reg <= emit;
            end
            if (!out_valid_reg || m_tready)
            begin
                out_valid_reg <= jv_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (emit)
            begin
                jbin_reg  <= jbin_next;
                jlast_reg <= jlast_next;
            end
            if (jv_reg)
            begin
                out_bin_reg    <= 9'(jbin_reg);
                out_range_reg  <= j_range;
                out_status_reg <= j_status;
                out_last_reg   <= jlast_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_range_reg, out_bin_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- tb/lidar_scan_hole_fill_hold_checker.sv -----
// Scoreboard for the lidar scan hole-fill and hold cleaner: watches the config port
// and both streams, predicts every cleaned bin word and compares it. Uses lhfh_pkg.
`timescale 1ns / 1ps

module lidar_scan_hole_fill_hold_checker
    import lhfh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,   // [15:0] sample_mm, [63:16] frame_time_us
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [8:0] bin_number, [24:9] range_mm, [31:25] zero
    input  wire logic [2:0]  m_tuser,   // [2:0] status
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        bin_t    bin_no;
        range_t  mm;
        status_t status;
        logic    tail;
    } bin_result_t;

    cfg_bin_t   win_first;
    cfg_bin_t   win_last;
    hold_time_t hold_limit;
    range_t     clear_mm;

    range_t held_mm [BINS];
    stamp_t held_at [BINS];
    range_t scan_mm [BINS];
    int     next_bin;
    stamp_t scan_stamp;

    bin_result_t due_q[$];

    function automatic int wrap_bin(int b, int d);
        return (((b + d) % BINS) + BINS) % BINS;
    endfunction

    // Judge one bin against the current scan and hold store, and queue its word.
    task automatic judge_bin(input int b);
        range_t  raw;
        range_t  best;
        range_t  nb;
        range_t  mm;
        status_t st;
        raw  = scan_mm[b];
        best = '0;
        if (raw != 0) begin
            mm = raw;
            st = ST_MEASURED;
        end
        else if (b >= win_first && b <= win_last) begin
            for (int d = -HALF_WIN; d <= HALF_WIN; d++) begin
                nb = scan_mm[wrap_bin(b, d)];
                if (nb != 0 && (best == 0 || nb < best))
                    best = nb;
            end
            if (best != 0) begin
                mm = best;
                st = ST_FILLED;
            end
            else if (scan_stamp < held_at[b] ||
                     scan_stamp - held_at[b] <= stamp_t'(hold_limit)) begin
                mm = held_mm[b];
                st = ST_HELD;
            end
            else begin
                mm = '0;
                st = ST_UNKNOWN;
            end
        end
        else begin
            mm = clear_mm;
            st = ST_CLEAR;
        end
        if (st == ST_MEASURED || st == ST_FILLED) begin
            held_mm[b] = mm;
            held_at[b] = scan_stamp;
        end
        due_q.push_back('{bin_t'(b), mm, st, 1'b0});
    endtask

    task automatic take_word(input range_t smp, input stamp_t ft);
        int          i;
        int          n0;
        bin_result_t closing;
        i  = next_bin;
        n0 = due_q.size();
        if (i == 0)
            scan_stamp = ft;
        scan_mm[i] = smp;
        if (i >= 2 * HALF_WIN)
            judge_bin(i - HALF_WIN);
        if (i == BINS - 1) begin
            for (int b = BINS - HALF_WIN; b < BINS; b++)
                judge_bin(b);
            for (int b = 0; b < HALF_WIN && b < BINS - HALF_WIN; b++)
                judge_bin(b);
            next_bin = 0;
        end
        else begin
            next_bin = i + 1;
        end
        if (due_q.size() > n0) begin
            closing = due_q.pop_back();
            closing.tail = 1'b1;
            due_q.push_back(closing);
        end
    endtask

    task automatic check_word(input logic [31:0] data, input logic [2:0] user, input logic lst);
        bin_result_t want;
        if (due_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected word: bin %0d range %0d status %0d last %0d",
                         data[8:0], data[24:9], user, lst);
        end
        else begin
            want = due_q.pop_front();
            if (data[8:0] != want.bin_no || data[24:9] != want.mm ||
                user != want.status || lst != want.tail) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch: expected bin %0d range %0d status %0d last %0d,",
                             want.bin_no, want.mm, want.status, want.tail,
                             " got bin %0d range %0d status %0d last %0d",
                             data[8:0], data[24:9], user, lst);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_first  = FRONT_FIRST_RST;
            win_last   = FRONT_LAST_RST;
            hold_limit = HOLD_TIME_RST;
            clear_mm   = CLEAR_RANGE_RST;
            for (int k = 0; k < BINS; k++) begin
                held_mm[k] = CLEAR_RANGE_RST;
                held_at[k] = '0;
                scan_mm[k] = '0;
            end
            next_bin   = 0;
            scan_stamp = '0;
            due_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FRONT_FIRST: win_first  = cfg_data[CFG_BIN_W-1:0];
                    REG_FRONT_LAST:  win_last   = cfg_data[CFG_BIN_W-1:0];
                    REG_HOLD_TIME:   hold_limit = cfg_data[HOLD_T_W-1:0];
                    REG_CLEAR_RANGE: clear_mm   = cfg_data[RANGE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_word(s_tdata[15:0], s_tdata[63:16]);
            if (m_tvalid && m_tready)
                check_word(m_tdata, m_tuser, m_tlast);
            pending = due_q.size();
        end
    end

endmodule

// ----- tb/lidar_scan_hole_fill_hold_tb.sv -----
// Top of the testbench for lidar_scan_hole_fill_hold: clock, reset, stimulus and verdict.
// Depends on lhfh_pkg, the block itself and lidar_scan_hole_fill_hold_checker.
`timescale 1ns / 1ps

module lidar_scan_hole_fill_hold_tb;
    import lhfh_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_FRONT_FIRST;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;    // [15:0] sample_mm, [63:16] frame_time_us
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // [8:0] bin_number, [24:9] range_mm, [31:25] zero
    logic [2:0]  m_tuser;           // [2:0] status
    logic        m_tlast;

    int fail_count;
    int pending;

    // Bin position of the next word sent, and the frame time it carries at bin 0.
    int     scan_pos = 0;
    stamp_t scan_start_stamp;
    // Words still to come in a forced run of empty bins.
    int     hole_left = 0;
    // Sender burst and receiver pacing state.
    int     tx_burst_left = 0;
    int     rx_stall_left = 0;
    int     rx_mode_left  = 0;
    logic   rx_calm       = 1'b0;

    always #10 clk = ~clk;

    lidar_scan_hole_fill_hold u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lidar_scan_hole_fill_hold_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Length of an idle stretch: mostly short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 9);
        return $urandom_range(10, 40);
    endfunction

    // Random raw range. Empty bins come alone or in runs, so that the fill window
    // sometimes finds a neighbor and sometimes falls through to the hold store.
    function automatic range_t random_sample();
        int r;
        if (hole_left > 0) begin
            hole_left--;
            return '0;
        end
        r = $urandom_range(0, 99);
        if (r < 20)
            return '0;
        if (r < 30) begin
            hole_left = $urandom_range(2, 7);
            return '0;
        end
        if (r < 34)
            return 16'd1;
        if (r < 38)
            return 16'hFFFF;
        return range_t'($urandom_range(1, 65535));
    endfunction

    // The receiver stalls at random, except during calm stretches where it starts no
    // new stall. The mode is picked again when its random stretch runs out.
    always @(negedge clk)
    begin
        if (rx_mode_left == 0) begin
            rx_calm      = ($urandom_range(0, 3) == 0);
            rx_mode_left = $urandom_range(20, 120);
        end
        else begin
            rx_mode_left--;
        end
        if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end
        else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_stall_left = pick_gap() - 1;
        end
        else begin
            m_tready <= 1'b1;
        end
    end

    // Write all four registers on consecutive cycles with the enable held high.
    task automatic set_config(input cfg_bin_t first_bin, input cfg_bin_t last_bin,
                              input hold_time_t hold_us, input range_t clear_val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRONT_FIRST;
        cfg_data  <= 32'(first_bin);
        @(negedge clk);
        cfg_index <= REG_FRONT_LAST;
        cfg_data  <= 32'(last_bin);
        @(negedge clk);
        cfg_index <= REG_HOLD_TIME;
        cfg_data  <= 32'(hold_us);
        @(negedge clk);
        cfg_index <= REG_CLEAR_RANGE;
        cfg_data  <= 32'(clear_val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Send one bin word and wait until it is taken. Only the word of bin 0 carries
    // a meaningful frame time; the rest get random stamps that the block ignores.
    task automatic push_word(input range_t smp);
        int     gap;
        stamp_t ft;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 29) == 0) begin
            tx_burst_left = $urandom_range(20, 80);
            gap = 0;
        end
        else begin
            gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        ft = (scan_pos == 0) ? scan_start_stamp : stamp_t'({$urandom, $urandom});
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {ft, smp};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        scan_pos = (scan_pos + 1) % BINS;
    endtask

    // Stop sending and let every predicted word come out. The first bins of a scan
    // release nothing, so an extra wait afterwards covers work still inside the block.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        range_t opening [25];
        opening = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                    16'd300, 16'd0, 16'd300, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd2,
                    16'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd9, 16'd0};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Opening scan, bins 0 to 24: a full-width window, the reset hold time and
        // clear range. The frame time of 100 us keeps the cleared hold entries
        // (8000 mm at time 0) fresh, so unfilled holes report the reset hold value.
        // Bin 0 is empty and is only judged at the end of the scan, against the
        // wrapped-around neighbors. Runs of empty bins defeat the fill window.
        // The block is still clearing its hold store here; words wait for ready.
        scan_start_stamp = 48'd100;
        set_config(9'd0, 9'd359, HOLD_TIME_RST, CLEAR_RANGE_RST);
        foreach (opening[k])
            push_word(opening[k]);
        drain();

        // Narrow window with a zero hold time: stale holds turn unknown, and bins on
        // both sides of the window report the largest clear range.
        set_config(9'd40, 9'd100, 32'd0, 16'hFFFF);
        repeat (95) push_word(random_sample());
        drain();

        // Inverted window starting at the top bin: every empty bin is clear, and a
        // clear range of zero is reported as is.
        set_config(9'd359, 9'd150, 32'hFFFF_FFFF, 16'd0);
        repeat (60) push_word(random_sample());
        drain();

        // Random window and hold settings across most of the rest of the scan.
        set_config(cfg_bin_t'($urandom_range(180, 250)), cfg_bin_t'($urandom_range(300, 355)),
                   hold_time_t'($urandom), range_t'($urandom_range(0, 65535)));
        repeat (176) push_word(random_sample());
        drain();

        // Across the end of the scan with a full window, so the wrapped bins fill
        // from both ends. The next scan starts at 50 us, earlier than the 100 us
        // stamp of bins written in the first scan, which therefore count as fresh;
        // bins still at stamp 0 are 50 us old, one past the 49 us hold time.
        scan_start_stamp = 48'd50;
        set_config(9'd0, 9'd359, 32'd49, range_t'($urandom_range(0, 65535)));
        repeat (34) push_word(random_sample());
        drain();

        // Hold time equal to the age of never-written entries: exactly at the limit
        // still counts as held.
        set_config(9'd28, 9'd300, 32'd50, range_t'($urandom_range(0, 65535)));
        repeat (20) push_word(random_sample());
        drain();

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the clearing pass.
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
